@@ design/htesp_pkg.sv @@
`default_nettype none

package htesp_pkg;

   // table geometry
   localparam int INDEX_BITS_DEF = 16;
   localparam int CHECK_W        = 64;
   localparam int DATA_W         = 42;
   localparam int MEM_W          = CHECK_W + DATA_W;

   // field widths
   localparam int SCORE_W = 18;
   localparam int MATE_W  = 17;
   localparam int SQ_W    = 6;
   localparam int TYPE_W  = 4;
   localparam int FLAG_W  = 2;
   localparam int DEPTH_W = 6;
   localparam int PLY_W   = 7;

   // stream payload widths
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 48;

   // data word layout
   localparam int TO_LSB    = 0;
   localparam int FROM_LSB  = 6;
   localparam int TYPE_LSB  = 12;
   localparam int SCORE_LSB = 16;
   localparam int DEPTH_LSB = 34;
   localparam int FLAG_LSB  = 40;

   // response payload bit positions
   localparam int RSP_HIT_BIT     = 0;
   localparam int RSP_WRITTEN_BIT = 1;

   // operation codes
   localparam logic FUNC_PROBE = 1'b0;
   localparam logic FUNC_STORE = 1'b1;

   // register indexes
   localparam int           CSR_IDX_W        = 2;
   localparam int           CSR_DATA_W       = 18;
   localparam logic [1:0]   REG_SCORE_OFFSET = 2'd0;
   localparam logic [1:0]   REG_MATE_SCORE   = 2'd1;
   localparam logic [1:0]   REG_MATE_MARGIN  = 2'd2;
   localparam logic [1:0]   REG_REJECT_MAG   = 2'd3;

   // register reset values
   localparam logic [SCORE_W-1:0] SCORE_OFFSET_RST = 18'd100000;
   localparam logic [MATE_W-1:0]  MATE_SCORE_RST   = 17'd50000;
   localparam logic [MATE_W-1:0]  MATE_MARGIN_RST  = 17'd1000;
   localparam logic [MATE_W-1:0]  REJECT_MAG_RST   = 17'd120000;

   typedef struct packed {
      logic [SCORE_W-1:0] score_offset;
      logic [MATE_W-1:0]  mate_score;
      logic [MATE_W-1:0]  mate_margin;
      logic [MATE_W-1:0]  reject_mag;
   } cfg_type;

   // one request in flight at the memory output
   typedef struct packed {
      logic                      func;
      logic [CHECK_W-1:0]        key;
      logic [FLAG_W-1:0]         flag;
      logic [DEPTH_W-1:0]        depth;
      logic [PLY_W-1:0]          ply;
      logic signed [SCORE_W-1:0] score;
      logic [SQ_W-1:0]           move_from;
      logic [SQ_W-1:0]           move_to;
      logic [TYPE_W-1:0]         move_type;
   } req_type;

   // decoded probe result
   typedef struct packed {
      logic                      hit;
      logic [FLAG_W-1:0]         flag;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] score;
      logic [SQ_W-1:0]           from;
      logic [SQ_W-1:0]           to;
      logic [TYPE_W-1:0]         mtype;
   } prb_type;

   // signed mate threshold: mate_score - mate_margin
   function automatic logic signed [18:0] mate_thr(input cfg_type cfg);
      logic signed [18:0] ms;
      logic signed [18:0] mm;
      ms = $signed({2'b00, cfg.mate_score});
      mm = $signed({2'b00, cfg.mate_margin});
      return ms - mm;
   endfunction

   // move a mate score away from zero by ply on store, back on read
   function automatic logic signed [19:0] mate_adj(input logic signed [19:0] s,
                                                   input logic [PLY_W-1:0] ply,
                                                   input logic signed [18:0] thr,
                                                   input logic to_store);
      logic signed [19:0] thr_w;
      logic signed [19:0] nthr_w;
      logic signed [19:0] ply_w;
      logic signed [19:0] res;
      thr_w  = $signed({thr[18], thr});
      nthr_w = -thr_w;
      ply_w  = $signed({13'b0, ply});
      if (s >= thr_w) begin
         res = to_store ? s + ply_w : s - ply_w;
      end else if (s <= nthr_w) begin
         res = to_store ? s - ply_w : s + ply_w;
      end else begin
         res = s;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/hash_table_entry_store_probe.sv @@
// Pipeline: a request passes stage one, then the response register, to rsp_tvalid.
// Throughput: one transaction per cycle unless a stall or clearing pass holds it;
//   a probe right behind a store to its entry takes the stored word by forwarding.
// Reset: registers return to their reset values, then a clearing pass zeroes all
//   2^INDEX_BITS entries with req_tready low.
`default_nettype none

module hash_table_entry_store_probe #(
   parameter int INDEX_BITS = htesp_pkg::INDEX_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: key[63:0] flag[65:64] depth[71:66] ply[78:72] score[96:79]
   //          move_from[102:97] move_to[108:103] move_type[112:109]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [htesp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: func
   input  wire logic                              req_tuser,
   // response: hit[0] written[1] entry_flag[3:2] entry_depth[9:4]
   //           entry_score[27:10] entry_from[33:28] entry_to[39:34]
   //           entry_type[43:40]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [htesp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [htesp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [htesp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import htesp_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;

   logic                  clr_busy;
   logic [INDEX_BITS-1:0] clr_addr;

   req_type               req;
   logic                  accept;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   req_type               s1_ff;
   logic                  s1_fwd_ff;
   logic                  s1_fwd_in;
   logic [MEM_W-1:0]      s1_fwd_word_ff;
   logic                  s1_go;

   logic [DATA_W-1:0]     st_data;
   logic [CHECK_W-1:0]    st_check;
   logic                  st_ok;
   logic                  item_wr;

   logic                  mem_wr_en;
   logic [INDEX_BITS-1:0] mem_wr_addr;
   logic [MEM_W-1:0]      mem_wr_word;
   logic [MEM_W-1:0]      mem_rd_word;
   logic [MEM_W-1:0]      probe_word;
   prb_type               prb;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_in;

   // configuration registers
   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SCORE_OFFSET: cfg_in.score_offset = csr_data[SCORE_W-1:0];
            REG_MATE_SCORE:   cfg_in.mate_score   = csr_data[MATE_W-1:0];
            REG_MATE_MARGIN:  cfg_in.mate_margin  = csr_data[MATE_W-1:0];
            REG_REJECT_MAG:   cfg_in.reject_mag   = csr_data[MATE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_offset <= SCORE_OFFSET_RST;
         cfg_ff.mate_score   <= MATE_SCORE_RST;
         cfg_ff.mate_margin  <= MATE_MARGIN_RST;
         cfg_ff.reject_mag   <= REJECT_MAG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // clearing pass after reset
   htesp_clear #(
      .INDEX_BITS (INDEX_BITS)
   ) u_clear (
      .clock (clock),
      .reset (reset),
      .busy  (clr_busy),
      .addr  (clr_addr)
   );

   // unpack the request payload
   always_comb begin
      req.func      = req_tuser;
      req.key       = req_tdata[63:0];
      req.flag      = req_tdata[65:64];
      req.depth     = req_tdata[71:66];
      req.ply       = req_tdata[78:72];
      req.score     = req_tdata[96:79];
      req.move_from = req_tdata[102:97];
      req.move_to   = req_tdata[108:103];
      req.move_type = req_tdata[112:109];
   end

   // stage one advances when the response register is free
   assign s1_go      = !rsp_valid_ff || rsp_tready;
   assign req_tready = !clr_busy && (!s1_valid_ff || s1_go);
   assign accept     = req_tvalid && req_tready;

   // build the entry for a store
   htesp_pack u_pack (
      .cfg       (cfg_ff),
      .key       (s1_ff.key),
      .flag      (s1_ff.flag),
      .depth     (s1_ff.depth),
      .ply       (s1_ff.ply),
      .score     (s1_ff.score),
      .move_from (s1_ff.move_from),
      .move_to   (s1_ff.move_to),
      .move_type (s1_ff.move_type),
      .data      (st_data),
      .check     (st_check),
      .write_ok  (st_ok)
   );

   // write a store as it leaves stage one, or zero during the clearing pass
   assign item_wr     = s1_valid_ff && s1_go && (s1_ff.func == FUNC_STORE) && st_ok;
   assign mem_wr_en   = clr_busy || item_wr;
   assign mem_wr_addr = clr_busy ? clr_addr : s1_ff.key[INDEX_BITS-1:0];
   assign mem_wr_word = clr_busy ? '0 : {st_check, st_data};

   htesp_mem #(
      .INDEX_BITS (INDEX_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_word (mem_wr_word),
      .rd_en   (accept),
      .rd_addr (req.key[INDEX_BITS-1:0]),
      .rd_word (mem_rd_word)
   );

   // forward a write that lands on the same entry at the read edge
   assign s1_fwd_in   = item_wr && (s1_ff.key[INDEX_BITS-1:0] == req.key[INDEX_BITS-1:0]);
   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff          <= req;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_word_ff <= {st_check, st_data};
      end
   end

   assign probe_word = s1_fwd_ff ? s1_fwd_word_ff : mem_rd_word;

   htesp_unpack u_unpack (
      .cfg  (cfg_ff),
      .key  (s1_ff.key),
      .ply  (s1_ff.ply),
      .word (probe_word),
      .prb  (prb)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_tdata_in = rsp_tdata_ff;
      if (s1_valid_ff && s1_go) begin
         rsp_valid_in = 1'b1;
         rsp_tdata_in = '0;
         if (s1_ff.func == FUNC_STORE) begin
            rsp_tdata_in[RSP_WRITTEN_BIT] = st_ok;
         end else begin
            rsp_tdata_in[RSP_HIT_BIT] = prb.hit;
            rsp_tdata_in[3:2]         = prb.flag;
            rsp_tdata_in[9:4]         = prb.depth;
            rsp_tdata_in[27:10]       = prb.score;
            rsp_tdata_in[33:28]       = prb.from;
            rsp_tdata_in[39:34]       = prb.to;
            rsp_tdata_in[43:40]       = prb.mtype;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // no transaction is in flight while the table is being cleared
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("transaction in flight during clearing pass");

   // a stalled response keeps stage one holding its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stage one lost its item under backpressure");

   // a store result never reports a hit
   a_store_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tdata_ff[RSP_WRITTEN_BIT]) |-> !rsp_tdata_ff[RSP_HIT_BIT])
      else $error("store result carries a hit");

   // a table write from a store happens only with the result moving out
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      item_wr |=> (rsp_valid_ff && rsp_tdata_ff[RSP_WRITTEN_BIT]))
      else $error("table write without a written result");

endmodule

`default_nettype wire

@@ design/htesp_mem.sv @@
`default_nettype none

module htesp_mem #(
   parameter int INDEX_BITS = htesp_pkg::INDEX_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [INDEX_BITS-1:0]       wr_addr,
   input  wire logic [htesp_pkg::MEM_W-1:0] wr_word,
   input  wire logic                        rd_en,
   input  wire logic [INDEX_BITS-1:0]       rd_addr,
   output logic      [htesp_pkg::MEM_W-1:0] rd_word
);
   import htesp_pkg::*;

   localparam int DEPTH = 1 << INDEX_BITS;

   logic [MEM_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/htesp_clear.sv @@
`default_nettype none

module htesp_clear #(
   parameter int INDEX_BITS = htesp_pkg::INDEX_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   output logic                       busy,
   output logic [INDEX_BITS-1:0]      addr
);
   import htesp_pkg::*;

   logic                  busy_ff;
   logic                  busy_in;
   logic [INDEX_BITS-1:0] addr_ff;
   logic [INDEX_BITS-1:0] addr_in;

   // sweep every entry once after reset
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + INDEX_BITS'(1);
         if (addr_ff == {INDEX_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign busy = busy_ff;
   assign addr = addr_ff;

endmodule

`default_nettype wire

@@ design/htesp_pack.sv @@
`default_nettype none

module htesp_pack (
   input  wire htesp_pkg::cfg_type               cfg,
   input  wire logic [htesp_pkg::CHECK_W-1:0]    key,
   input  wire logic [htesp_pkg::FLAG_W-1:0]     flag,
   input  wire logic [htesp_pkg::DEPTH_W-1:0]    depth,
   input  wire logic [htesp_pkg::PLY_W-1:0]      ply,
   input  wire logic signed [htesp_pkg::SCORE_W-1:0] score,
   input  wire logic [htesp_pkg::SQ_W-1:0]       move_from,
   input  wire logic [htesp_pkg::SQ_W-1:0]       move_to,
   input  wire logic [htesp_pkg::TYPE_W-1:0]     move_type,
   output logic      [htesp_pkg::DATA_W-1:0]     data,
   output logic      [htesp_pkg::CHECK_W-1:0]    check,
   output logic                                  write_ok
);
   import htesp_pkg::*;

   logic signed [19:0]   score_w;
   logic signed [19:0]   mag;
   logic signed [19:0]   adj;
   logic [SCORE_W-1:0]   packed_score;

   // drop a store whose magnitude equals the fail score
   assign score_w  = $signed({{2{score[SCORE_W-1]}}, score});
   assign mag      = score_w[19] ? -score_w : score_w;
   assign write_ok = (mag != $signed({3'b000, cfg.reject_mag}));

   // mate adjust, add offset, keep the low bits
   assign adj = mate_adj(score_w, ply, mate_thr(cfg), 1'b1)
                + $signed({2'b00, cfg.score_offset});
   assign packed_score = adj[SCORE_W-1:0];

   assign data  = {flag, depth, packed_score, move_type, move_from, move_to};
   assign check = key ^ {{(CHECK_W-DATA_W){1'b0}}, data};

endmodule

`default_nettype wire

@@ design/htesp_unpack.sv @@
`default_nettype none

module htesp_unpack (
   input  wire htesp_pkg::cfg_type            cfg,
   input  wire logic [htesp_pkg::CHECK_W-1:0] key,
   input  wire logic [htesp_pkg::PLY_W-1:0]   ply,
   input  wire logic [htesp_pkg::MEM_W-1:0]   word,
   output htesp_pkg::prb_type                 prb
);
   import htesp_pkg::*;

   logic [DATA_W-1:0]  data;
   logic [CHECK_W-1:0] check;
   logic signed [19:0] raw;
   logic signed [19:0] adj;

   assign data  = word[DATA_W-1:0];
   assign check = word[MEM_W-1:DATA_W];

   // remove offset, then read a mate score back by ply
   assign raw = $signed({2'b00, data[SCORE_LSB +: SCORE_W]})
                - $signed({2'b00, cfg.score_offset});
   assign adj = mate_adj(raw, ply, mate_thr(cfg), 1'b0);

   always_comb begin
      prb.hit   = ((check ^ {{(CHECK_W-DATA_W){1'b0}}, data}) == key);
      prb.flag  = data[FLAG_LSB +: FLAG_W];
      prb.depth = data[DEPTH_LSB +: DEPTH_W];
      prb.score = adj[SCORE_W-1:0];
      prb.from  = data[FROM_LSB +: SQ_W];
      prb.to    = data[TO_LSB +: SQ_W];
      prb.mtype = data[TYPE_LSB +: TYPE_W];
   end

endmodule

`default_nettype wire

@@ test/entry_store_checker.sv @@
module entry_store_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [htesp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [htesp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [htesp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [htesp_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               outstanding,
   output int                               mismatches
);
   timeunit 1ns;
   timeprecision 1ps;
   import htesp_pkg::*;

   localparam int TBL_DEPTH = 1 << INDEX_BITS_DEF;

   // one decoded result transaction
   typedef struct packed {
      logic                      hit;
      logic                      written;
      logic [FLAG_W-1:0]         flag;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] score;
      logic [SQ_W-1:0]           src_sq;
      logic [SQ_W-1:0]           dst_sq;
      logic [TYPE_W-1:0]         kind;
   } entry_result_type;

   cfg_type            regs;
   logic [CHECK_W-1:0] check_mem [TBL_DEPTH];
   logic [DATA_W-1:0]  data_mem  [TBL_DEPTH];
   entry_result_type   expected_entries [$];
   int                 fail_count = 0;

   assign mismatches = fail_count;

   // the table starts out all zero
   initial begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
         check_mem[i] = '0;
         data_mem[i]  = '0;
      end
   end

   // push a mate score away from zero by ply on store, pull it back on probe
   function automatic int shift_mate(input int s, input int ply, input int dir);
      int thr;
      thr = int'(regs.mate_score) - int'(regs.mate_margin);
      if (s >= thr) return s + dir * ply;
      if (s <= -thr) return s - dir * ply;
      return s;
   endfunction

   // apply one request to the table copy and return the result it must produce
   function automatic entry_result_type predict_entry(input req_type rq);
      entry_result_type  res;
      int unsigned       slot;
      int                sc;
      int                adj;
      logic [DATA_W-1:0] word;
      res  = '0;
      slot = 32'(rq.key[INDEX_BITS_DEF-1:0]);
      if (rq.func == FUNC_STORE) begin
         sc = rq.score;
         // a fail score leaves the entry alone
         if ((sc < 0 ? -sc : sc) == int'(regs.reject_mag)) return res;
         adj  = shift_mate(sc, rq.ply, 1) + int'(regs.score_offset);
         word = {rq.flag, rq.depth, adj[SCORE_W-1:0], rq.move_type, rq.move_from,
                 rq.move_to};
         data_mem[slot]  = word;
         check_mem[slot] = rq.key ^ CHECK_W'(word);
         res.written     = 1'b1;
      end else begin
         word = data_mem[slot];
         sc   = int'(word[SCORE_LSB +: SCORE_W]) - int'(regs.score_offset);
         sc   = shift_mate(sc, rq.ply, -1);
         // fields decode even on a miss
         res.hit    = ((check_mem[slot] ^ CHECK_W'(word)) == rq.key);
         res.flag   = word[FLAG_LSB +: FLAG_W];
         res.depth  = word[DEPTH_LSB +: DEPTH_W];
         res.score  = sc[SCORE_W-1:0];
         res.src_sq = word[FROM_LSB +: SQ_W];
         res.dst_sq = word[TO_LSB +: SQ_W];
         res.kind   = word[TYPE_LSB +: TYPE_W];
      end
      return res;
   endfunction

   task automatic compare_field(input string fname, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      req_type          rq;
      entry_result_type want;
      entry_result_type got;
      if (reset) begin
         regs.score_offset = SCORE_OFFSET_RST;
         regs.mate_score   = MATE_SCORE_RST;
         regs.mate_margin  = MATE_MARGIN_RST;
         regs.reject_mag   = REJECT_MAG_RST;
         expected_entries.delete();
      end else begin
         // track register writes, masked to each register's width
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SCORE_OFFSET: regs.score_offset = csr_data[SCORE_W-1:0];
               REG_MATE_SCORE:   regs.mate_score   = csr_data[MATE_W-1:0];
               REG_MATE_MARGIN:  regs.mate_margin  = csr_data[MATE_W-1:0];
               REG_REJECT_MAG:   regs.reject_mag   = csr_data[MATE_W-1:0];
               default: ;
            endcase
         end

         // compare a result transaction with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got.hit     = rsp_tdata[RSP_HIT_BIT];
            got.written = rsp_tdata[RSP_WRITTEN_BIT];
            got.flag    = rsp_tdata[3:2];
            got.depth   = rsp_tdata[9:4];
            got.score   = rsp_tdata[27:10];
            got.src_sq  = rsp_tdata[33:28];
            got.dst_sq  = rsp_tdata[39:34];
            got.kind    = rsp_tdata[43:40];
            if (expected_entries.size() == 0) begin
               $error("result transaction with nothing expected: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_entries.pop_front();
               compare_field("hit", want.hit, got.hit);
               compare_field("written", want.written, got.written);
               compare_field("entry_flag", want.flag, got.flag);
               compare_field("entry_depth", want.depth, got.depth);
               compare_field("entry_score", want.score, got.score);
               compare_field("entry_from", want.src_sq, got.src_sq);
               compare_field("entry_to", want.dst_sq, got.dst_sq);
               compare_field("entry_type", want.kind, got.kind);
            end
         end

         // predict an accepted request transaction
         if (req_tvalid && req_tready) begin
            rq.func      = req_tuser;
            rq.key       = req_tdata[63:0];
            rq.flag      = req_tdata[65:64];
            rq.depth     = req_tdata[71:66];
            rq.ply       = req_tdata[78:72];
            rq.score     = req_tdata[96:79];
            rq.move_from = req_tdata[102:97];
            rq.move_to   = req_tdata[108:103];
            rq.move_type = req_tdata[112:109];
            expected_entries.push_back(predict_entry(rq));
         end
      end
      outstanding <= expected_entries.size();
   end

endmodule

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import htesp_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   int                    outstanding;
   int                    mismatches;

   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int          fail_now      = int'(REJECT_MAG_RST);
   int          mate_thr_now  = MATE_SCORE_RST - MATE_MARGIN_RST;
   logic [63:0] stored_keys [$];

   hash_table_entry_store_probe DUT (.*);

   entry_store_checker u_checker (.*);

   initial forever #6ns clock = ~clock;

   // stall the result side at random
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   function automatic req_type make_req(input logic func, input logic [63:0] key,
                                        input int flag, input int depth, input int ply,
                                        input int score, input int src, input int dst,
                                        input int kind);
      req_type rq;
      rq.func      = func;
      rq.key       = key;
      rq.flag      = flag[FLAG_W-1:0];
      rq.depth     = depth[DEPTH_W-1:0];
      rq.ply       = ply[PLY_W-1:0];
      rq.score     = score[SCORE_W-1:0];
      rq.move_from = src[SQ_W-1:0];
      rq.move_to   = dst[SQ_W-1:0];
      rq.move_type = kind[TYPE_W-1:0];
      return rq;
   endfunction

   // drive one request transaction, with random idle cycles ahead of it
   task automatic send_req(input req_type rq);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.func;
      req_tdata  <= {7'b0, rq.move_type, rq.move_to, rq.move_from, rq.score, rq.ply,
                     rq.depth, rq.flag, rq.key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // remember recent keys so later probes can hit
      if (rq.func == FUNC_STORE) begin
         stored_keys.push_back(rq.key);
         if (stored_keys.size() > 32) void'(stored_keys.pop_front());
      end
   endtask

   // hold the request side until every result has come back
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input int offset, input int mate, input int margin,
                               input int fail);
      int                   vals [4];
      logic [CSR_IDX_W-1:0] ids [4];
      vals = '{offset, mate, margin, fail};
      ids  = '{REG_SCORE_OFFSET, REG_MATE_SCORE, REG_MATE_MARGIN, REG_REJECT_MAG};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= ids[i];
         csr_data  <= vals[i][CSR_DATA_W-1:0];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      // keep the score picker aimed at the new thresholds
      fail_now     = fail & 'h1FFFF;
      mate_thr_now = (mate & 'h1FFFF) - (margin & 'h1FFFF);
   endtask

   task automatic run_random(input int count);
      logic [63:0] k;
      int          r;
      int          sc;
      for (int n = 0; n < count; n++) begin
         // pick the key: revisit recent entries, collide on their index, crowd the low indexes, or roam
         r = $urandom_range(99);
         k = {$urandom, $urandom};
         if (r < 45 && stored_keys.size() > 0) begin
            k = stored_keys[$urandom_range(stored_keys.size() - 1)];
         end else if (r < 60 && stored_keys.size() > 0) begin
            k[INDEX_BITS_DEF-1:0] =
               stored_keys[$urandom_range(stored_keys.size() - 1)][INDEX_BITS_DEF-1:0];
         end else if (r < 75) begin
            k[INDEX_BITS_DEF-1:0] = INDEX_BITS_DEF'($urandom_range(15));
         end

         // pick the score: full range, fail score, mate threshold edge, small, extremes
         case ($urandom_range(9))
            0, 1, 2, 3: sc = int'($urandom_range(262143)) - 131072;
            4, 5:       sc = fail_now;
            6, 7:       sc = mate_thr_now + int'($urandom_range(6)) - 3;
            8:          sc = int'($urandom_range(200)) - 100;
            default:    sc = $urandom_range(1) ? 131071 : -131072;
         endcase
         if ($urandom_range(1)) sc = -sc;

         send_req(make_req($urandom_range(1) ? FUNC_STORE : FUNC_PROBE, k,
                           $urandom_range(3), $urandom_range(63), $urandom_range(127), sc,
                           $urandom_range(63), $urandom_range(63), $urandom_range(15)));
         if ($urandom_range(299) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty entry at index 0 hits for key 0, all-ones key misses
      send_req(make_req(FUNC_PROBE, 64'h0, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(FUNC_PROBE, '1, 3, 63, 127, -1, 63, 63, 15));
      // all fields but the score at maximum, then probe right behind the store
      send_req(make_req(FUNC_STORE, 64'hDEAD_BEEF_0123_0005, 3, 63, 127, 0, 63, 63, 15));
      send_req(make_req(FUNC_PROBE, 64'hDEAD_BEEF_0123_0005, 0, 0, 127, 0, 0, 0, 0));
      send_req(make_req(FUNC_PROBE, 64'hDEAD_BEFF_0123_0005, 0, 0, 0, 0, 0, 0, 0));
      // fail score of either sign is dropped
      send_req(make_req(FUNC_STORE, 64'hDEAD_BEEF_0123_0005, 1, 7, 3, 120000, 1, 2, 3));
      send_req(make_req(FUNC_STORE, 64'hDEAD_BEEF_0123_0005, 2, 9, 4, -120000, 4, 5, 6));
      send_req(make_req(FUNC_PROBE, 64'hDEAD_BEEF_0123_0005, 0, 0, 0, 0, 0, 0, 0));
      // mate band edges
      send_req(make_req(FUNC_STORE, 64'h0123_4567_89AB_0100, 1, 10, 10, 49000, 8, 9, 1));
      send_req(make_req(FUNC_PROBE, 64'h0123_4567_89AB_0100, 0, 0, 3, 0, 0, 0, 0));
      send_req(make_req(FUNC_STORE, 64'h0123_4567_89AB_0101, 2, 20, 20, -49000, 10, 11, 2));
      send_req(make_req(FUNC_PROBE, 64'h0123_4567_89AB_0101, 0, 0, 20, 0, 0, 0, 0));
      send_req(make_req(FUNC_STORE, 64'h0123_4567_89AB_0102, 0, 30, 50, 48999, 12, 13, 3));
      send_req(make_req(FUNC_PROBE, 64'h0123_4567_89AB_0102, 0, 0, 50, 0, 0, 0, 0));
      // extreme scores of both signs through the offset; the negative one wraps in 18 bits
      send_req(make_req(FUNC_STORE, 64'h5555_AAAA_5555_0200, 3, 1, 127, 131071, 0, 63, 4));
      send_req(make_req(FUNC_PROBE, 64'h5555_AAAA_5555_0200, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(FUNC_STORE, 64'hAAAA_5555_AAAA_0201, 0, 2, 127, -131072, 63, 0, 5));
      send_req(make_req(FUNC_PROBE, 64'hAAAA_5555_AAAA_0201, 0, 0, 127, 0, 0, 0, 0));
      // all-zero fields under the all-ones key, then a store at index 0
      send_req(make_req(FUNC_STORE, '1, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(FUNC_PROBE, '1, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(FUNC_STORE, 64'h0, 1, 1, 1, -5, 1, 1, 1));
      send_req(make_req(FUNC_PROBE, 64'h0, 0, 0, 1, 0, 0, 0, 0));
      send_req(make_req(FUNC_PROBE, 64'h0000_0001_0000_0000, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // random phases, each under a register setting and idle pattern chosen per phase
      for (int p = 0; p < 8; p++) begin
         case (p)
            1: write_config(0, 131071, 0, 131071);
            2: write_config(131072, 0, 131071, 0);
            3, 5: write_config($urandom_range(262143), $urandom_range(262143),
                               $urandom_range(262143), $urandom_range(262143));
            4: write_config(262143, 1000, 1000, 5);
            6: write_config(65536, 131071, 131071, 1);
            default: write_config(SCORE_OFFSET_RST, MATE_SCORE_RST, MATE_MARGIN_RST,
                                  REJECT_MAG_RST);
         endcase
         case (p % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin req_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         run_random(205);
         wait_drained();
      end

      if (mismatches == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   // give up on a hung run
   initial begin
      #10ms;
      $display("tb_top failed");
      $finish;
   end

endmodule
